>>> rtl/filament_motion_monitor_assert.svh
// Assertion macros shared by the filament motion monitor RTL
`ifndef FILAMENT_MOTION_MONITOR_ASSERT_SVH
`define FILAMENT_MOTION_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset
`define FMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset
`define FMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fmm_pkg.sv
// Types and constants shared by the filament motion monitor modules
`default_nettype none

package fmm_pkg;

  localparam int unsigned DATA_IN_W  = 128;
  localparam int unsigned DATA_OUT_W = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CNT_W      = 5;   // 32 multiply steps, one per elapsed bit

  localparam logic [16:0] TIME_SCALE = 17'd100000;
  localparam logic [7:0]  SLOW_MAX   = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DETECT_ENABLE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEPS_PER_MM      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ALARM_DISTANCE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_DISTANCE     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_START_DISTANCE    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOW_GAP_LIMIT    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FILE_START_OFFSET = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LIMIT       = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_MUL,
    ST_COMMIT
  } fmm_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scale;
    logic mul_step;
    logic commit;
  } fmm_cmd_t;

  typedef struct packed {
    logic needs_anchor;
    logic mul_last;
  } fmm_status_t;

endpackage

`default_nettype wire

>>> rtl/filament_motion_monitor.sv
// Top level of the filament motion monitor
//
//   Channel  Direction  Content
//   in_      slave      one poll or clear word per item
//   out_     master     beeper, break and block flags, one word per item
//   cfg_     write      detection registers, index 0 to 7
//
// A poll that re-anchors runs from acceptance through a product step, a scale
// step, 32 shift-add steps that test elapsed time against the feed-rate bound,
// and a commit step before its result is valid; the next word is taken after
// the commit. Clear items and other polls skip the scale and shift-add steps.
// Reset is synchronous (rst_n low); it restores register defaults and state.
// A held result stalls the commit; no new word is taken while it waits.
`default_nettype none

`include "filament_motion_monitor_assert.svh"

module filament_motion_monitor
  import fmm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // sensor_level, extruder_position, now_ms, feed_mm_per_s, feed_percent,
  // file_offset, printing_active, extruder_moving, zero fill
  input  wire logic [DATA_IN_W-1:0]  in_tdata,
  // clear
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // beeper_on, filament_break, filament_blocked, zero fill
  output logic [DATA_OUT_W-1:0]      out_tdata
);

  fmm_cmd_t    cmd;
  fmm_status_t status;

  fmm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  fmm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

  `FMM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "item taken while busy")
  `FMM_ASSERT_NOW(a_commit_slot_free, cmd.commit, !(out_tvalid && !out_tready), "result overwritten")
  `FMM_ASSERT_NOW(a_valid_from_commit, $rose(out_tvalid), $past(cmd.commit), "result without commit")

endmodule

`default_nettype wire

>>> rtl/fmm_ctrl.sv
// Sequencer for the filament motion monitor: handshakes and step commands
`default_nettype none

module fmm_ctrl
  import fmm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire fmm_status_t status,
  output fmm_cmd_t         cmd
);

  fmm_state_t state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       out_busy;

  assign out_busy = out_tvalid_r && !out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = status.needs_anchor ? ST_SCALE : ST_COMMIT;
      ST_SCALE:  state_nxt = ST_MUL;
      ST_MUL:    if (status.mul_last) state_nxt = ST_COMMIT;
      ST_COMMIT: if (!out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_PREP:   cmd.prep     = 1'b1;
      ST_SCALE:  cmd.scale    = 1'b1;
      ST_MUL:    cmd.mul_step = 1'b1;
      ST_COMMIT: cmd.commit   = !out_busy;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

  // hold the result word until taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) out_tvalid_nxt = 1'b0;
    if (cmd.commit) out_tvalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

`default_nettype wire

>>> rtl/fmm_dp.sv
// Datapath of the filament motion monitor: registers, state and slow-toggle test
`default_nettype none

module fmm_dp
  import fmm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [DATA_IN_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire fmm_cmd_t              cmd,
  output fmm_status_t                status,
  output logic [DATA_OUT_W-1:0]      out_tdata
);

  // configuration
  logic        en_r;
  logic [15:0] steps_r;
  logic [30:0] alarm_r, stop_r, start_r;
  logic [31:0] gap_lim_r, fso_r;
  logic [7:0]  blk_lim_r;

  // latched item
  logic        clear_r, level_r, printing_r, moving_r;
  logic [31:0] pos_r, now_r, offset_r;
  logic [15:0] feed_r;
  logic [9:0]  pct_r;

  // detector state
  logic        prev_level_r, prev_level_nxt;
  logic [31:0] anchor_pos_r, anchor_pos_nxt;
  logic [31:0] anchor_time_r, anchor_time_nxt;
  logic [7:0]  slow_cnt_r, slow_cnt_nxt;
  logic [31:0] dist_r, dist_nxt;
  logic        beeper_r, beeper_nxt;

  // slow test arithmetic
  logic [31:0]      d1_r;
  logic [48:0]      num_r;
  logic [31:0]      elapsed_r;
  logic [41:0]      div_r;
  logic [73:0]      acc_r;
  logic [CNT_W-1:0] cnt_r;

  logic        beeper_o_r, broken_o_r, blocked_o_r;

  logic        pass, needs_anchor, slow;
  logic [31:0] anchor_eff, gap;
  logic        alarm_hit, stop_hit, blocked_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b0;
      steps_r   <= 16'd400;
      alarm_r   <= 31'd6400;
      stop_r    <= 31'd8800;
      start_r   <= 31'd25600;
      gap_lim_r <= 32'd2400;
      fso_r     <= 32'd512;
      blk_lim_r <= 8'd15;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DETECT_ENABLE:     en_r      <= cfg_wdata[0];
        REG_STEPS_PER_MM:      steps_r   <= cfg_wdata[15:0];
        REG_ALARM_DISTANCE:    alarm_r   <= cfg_wdata[30:0];
        REG_STOP_DISTANCE:     stop_r    <= cfg_wdata[30:0];
        REG_START_DISTANCE:    start_r   <= cfg_wdata[30:0];
        REG_SLOW_GAP_LIMIT:    gap_lim_r <= cfg_wdata;
        REG_FILE_START_OFFSET: fso_r     <= cfg_wdata;
        REG_BLOCK_LIMIT:       blk_lim_r <= cfg_wdata[7:0];
        default:               en_r      <= en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clear_r    <= in_tuser;
      level_r    <= in_tdata[0];
      pos_r      <= in_tdata[32:1];
      now_r      <= in_tdata[64:33];
      feed_r     <= in_tdata[80:65];
      pct_r      <= in_tdata[90:81];
      offset_r   <= in_tdata[122:91];
      printing_r <= in_tdata[123];
      moving_r   <= in_tdata[124];
    end
  end

  assign pass = en_r && (offset_r >= fso_r) && !pos_r[31] && (pos_r >= {1'b0, start_r});
  // a poll at position zero empties the anchor first
  assign anchor_eff   = (pos_r == 32'd0) ? 32'd0 : anchor_pos_r;
  assign needs_anchor = !clear_r && pass &&
                        ((prev_level_r ^ level_r) || (anchor_eff == 32'd0));
  assign gap = pos_r - anchor_eff;

  // elapsed > floor(N/D)  <=>  elapsed*D > N, for nonzero D
  assign slow = (gap > gap_lim_r) && (div_r != 42'd0) && (acc_r > {25'd0, num_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      d1_r      <= {16'd0, steps_r} * {16'd0, feed_r};
      num_r     <= 49'(gap) * 49'(TIME_SCALE);
      elapsed_r <= now_r - anchor_time_r;
    end
    if (cmd.scale) begin
      div_r <= 42'(d1_r) * 42'(pct_r);
      acc_r <= '0;
      cnt_r <= '0;
    end
    // shift-add, elapsed MSB first
    if (cmd.mul_step) begin
      acc_r     <= {acc_r[72:0], 1'b0} + (elapsed_r[31] ? 74'(div_r) : 74'd0);
      elapsed_r <= {elapsed_r[30:0], 1'b0};
      cnt_r     <= cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    prev_level_nxt  = prev_level_r;
    anchor_pos_nxt  = anchor_pos_r;
    anchor_time_nxt = anchor_time_r;
    slow_cnt_nxt    = slow_cnt_r;
    dist_nxt        = dist_r;
    beeper_nxt      = beeper_r;
    alarm_hit       = 1'b0;
    stop_hit        = 1'b0;
    if (clear_r) begin
      anchor_pos_nxt  = 32'd0;
      slow_cnt_nxt    = 8'd0;
      dist_nxt        = 32'd0;
      beeper_nxt      = 1'b0;
      anchor_time_nxt = now_r;
    end else if (pass) begin
      prev_level_nxt = level_r;
      anchor_pos_nxt = anchor_eff;
      if (needs_anchor) begin
        if (slow) begin
          if (slow_cnt_r != SLOW_MAX) slow_cnt_nxt = slow_cnt_r + 8'd1;
        end else begin
          slow_cnt_nxt = 8'd0;
        end
        anchor_time_nxt = now_r;
        anchor_pos_nxt  = pos_r;
      end
      dist_nxt = pos_r - anchor_pos_nxt;
    end
    if (en_r && moving_r && (anchor_pos_nxt != 32'd0) && (pos_r != 32'd0)) begin
      alarm_hit = $signed(dist_nxt) >= $signed({1'b0, alarm_r});
      stop_hit  = $signed(dist_nxt) >= $signed({1'b0, stop_r});
    end
    if (!clear_r && pass && printing_r) beeper_nxt = alarm_hit;
  end

  assign blocked_nxt = en_r && (slow_cnt_nxt > blk_lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b0;
      anchor_pos_r  <= 32'd0;
      anchor_time_r <= 32'd0;
      slow_cnt_r    <= 8'd0;
      dist_r        <= 32'd0;
      beeper_r      <= 1'b0;
    end else if (cmd.commit) begin
      prev_level_r  <= prev_level_nxt;
      anchor_pos_r  <= anchor_pos_nxt;
      anchor_time_r <= anchor_time_nxt;
      slow_cnt_r    <= slow_cnt_nxt;
      dist_r        <= dist_nxt;
      beeper_r      <= beeper_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      beeper_o_r  <= beeper_nxt;
      broken_o_r  <= stop_hit;
      blocked_o_r <= blocked_nxt;
    end
  end

  assign status.needs_anchor = needs_anchor;
  assign status.mul_last     = (cnt_r == {CNT_W{1'b1}});
  assign out_tdata = {5'd0, blocked_o_r, broken_o_r, beeper_o_r};

endmodule

`default_nettype wire
